// File: hdl/qvr_pkg.sv
// Shared definitions for the quaternion vector rotation pipeline.
// Holds the default field widths and the term tables of the second product.
// Has no dependencies.
package qvr_pkg;

  localparam int unsigned VEC_WIDTH_DEF  = 16;
  localparam int unsigned QUAT_WIDTH_DEF = 16;

  localparam int unsigned NUM_QUAT  = 4;
  localparam int unsigned NUM_VEC   = 3;
  localparam int unsigned NUM_TERMS = 4;

  // Index codes of the quaternion components.
  localparam int unsigned QW = 0;
  localparam int unsigned QX = 1;
  localparam int unsigned QY = 2;
  localparam int unsigned QZ = 3;

  // Each output component is a sum of four products t[k] * q[j] with a sign.
  localparam int unsigned TERM_T [NUM_VEC][NUM_TERMS] = '{
    '{QX, QW, QY, QZ},
    '{QY, QW, QX, QZ},
    '{QZ, QW, QX, QY}
  };
  localparam int unsigned TERM_Q [NUM_VEC][NUM_TERMS] = '{
    '{QW, QX, QZ, QY},
    '{QW, QY, QZ, QX},
    '{QW, QZ, QY, QX}
  };
  localparam bit TERM_NEG [NUM_VEC][NUM_TERMS] = '{
    '{1'b0, 1'b1, 1'b1, 1'b0},
    '{1'b0, 1'b1, 1'b0, 1'b1},
    '{1'b0, 1'b1, 1'b1, 1'b0}
  };

endpackage

// File: hdl/qvr_round_sat.sv
// Rounding and saturation of one rotated component.
// Adds nothing itself: takes a value that already holds the rounding half,
// shifts out the fraction and clamps to the output width. Uses no package.
module qvr_round_sat #(
  parameter int unsigned IN_WIDTH   = 49,
  parameter int unsigned OUT_WIDTH  = 16,
  parameter int unsigned FRAC_SHIFT = 28
) (
  input  logic signed [IN_WIDTH-1:0]  value_i,
  output logic signed [OUT_WIDTH-1:0] value_o,
  output logic                        clip_o
);

  localparam int unsigned ShW = IN_WIDTH - FRAC_SHIFT;

  logic signed [ShW-1:0]       shifted;
  logic        [ShW-OUT_WIDTH:0] top_bits;
  logic                        fits;

  assign shifted  = ShW'(value_i >>> FRAC_SHIFT);
  assign top_bits = shifted[ShW-1:OUT_WIDTH-1];
  assign fits     = (&top_bits) | ~(|top_bits);
  assign clip_o   = ~fits;

  always_comb begin
    if (fits) begin
      value_o = shifted[OUT_WIDTH-1:0];
    end else if (shifted[ShW-1]) begin
      value_o = {1'b1, {(OUT_WIDTH-1){1'b0}}};
    end else begin
      value_o = {1'b0, {(OUT_WIDTH-1){1'b1}}};
    end
  end

endmodule

// File: hdl/quaternion_vector_rotate.sv
// Quaternion vector rotation, q * (0, v) * conj(q), rounded and saturated.
// Throughput is one beat per cycle while out_stall_i is low; every stage holds
// when the one after it is full and stalled, and empty stages fill while the
// output waits. Reset clears the stage valid bits only. Depends on qvr_pkg and
// qvr_round_sat.
module quaternion_vector_rotate #(
  parameter int unsigned VEC_WIDTH  = qvr_pkg::VEC_WIDTH_DEF,
  parameter int unsigned QUAT_WIDTH = qvr_pkg::QUAT_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [QUAT_WIDTH-1:0] quat_w_i,
  input  logic signed [QUAT_WIDTH-1:0] quat_x_i,
  input  logic signed [QUAT_WIDTH-1:0] quat_y_i,
  input  logic signed [QUAT_WIDTH-1:0] quat_z_i,
  input  logic signed [VEC_WIDTH-1:0]  vec_x_i,
  input  logic signed [VEC_WIDTH-1:0]  vec_y_i,
  input  logic signed [VEC_WIDTH-1:0]  vec_z_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [VEC_WIDTH-1:0]  rot_x_o,
  output logic signed [VEC_WIDTH-1:0]  rot_y_o,
  output logic signed [VEC_WIDTH-1:0]  rot_z_o,
  output logic                         clipped_o
);

  import qvr_pkg::*;

  localparam int unsigned NumStages = 6;
  localparam int unsigned PW        = VEC_WIDTH + QUAT_WIDTH;
  localparam int unsigned TW        = PW + 2;
  localparam int unsigned LW        = (TW + 1) / 2;
  localparam int unsigned HW        = TW - LW;
  localparam int unsigned LPW       = LW + 1 + QUAT_WIDTH;
  localparam int unsigned HPW       = HW + QUAT_WIDTH;
  localparam int unsigned LSW       = LPW + 2;
  localparam int unsigned HSW       = HPW + 2;
  localparam int unsigned RW        = TW + QUAT_WIDTH + 3;
  localparam int unsigned FracShift = 2 * (QUAT_WIDTH - 2);
  localparam logic [RW-1:0] RoundHalf = {{(RW-1){1'b0}}, 1'b1} << (FracShift - 1);

  logic [NumStages-1:0] valid_q, valid_d, adv;

  logic signed [QUAT_WIDTH-1:0] quat_in [NUM_QUAT];
  logic signed [VEC_WIDTH-1:0]  vec_in [NUM_VEC];

  logic signed [PW-1:0]         prod_d [NUM_VEC][NUM_QUAT];
  logic signed [PW-1:0]         prod_q [NUM_VEC][NUM_QUAT];
  logic signed [QUAT_WIDTH-1:0] quat0_q [NUM_QUAT];

  logic signed [TW-1:0]         tq_d [NUM_QUAT];
  logic signed [TW-1:0]         tq_q [NUM_QUAT];
  logic signed [QUAT_WIDTH-1:0] quat1_q [NUM_QUAT];

  logic signed [LPW-1:0] lo_d [NUM_VEC][NUM_TERMS];
  logic signed [LPW-1:0] lo_q [NUM_VEC][NUM_TERMS];
  logic signed [HPW-1:0] hi_d [NUM_VEC][NUM_TERMS];
  logic signed [HPW-1:0] hi_q [NUM_VEC][NUM_TERMS];

  logic signed [LSW-1:0] losum_d [NUM_VEC];
  logic signed [LSW-1:0] losum_q [NUM_VEC];
  logic signed [HSW-1:0] hisum_d [NUM_VEC];
  logic signed [HSW-1:0] hisum_q [NUM_VEC];

  logic signed [RW-1:0] rsum_d [NUM_VEC];
  logic signed [RW-1:0] rsum_q [NUM_VEC];

  logic signed [VEC_WIDTH-1:0] rot_d [NUM_VEC];
  logic signed [VEC_WIDTH-1:0] rot_q [NUM_VEC];
  logic        [NUM_VEC-1:0]   clip_vec;
  logic                        clip_q;

  // Handshake and stage advance.
  always_comb begin
    adv[NumStages-1] = ~valid_q[NumStages-1] | ~out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      adv[k] = ~valid_q[k] | adv[k+1];
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (adv[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (adv[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_stall_o  = ~adv[0];
  assign out_valid_o = valid_q[NumStages-1];

  assign quat_in[QW] = quat_w_i;
  assign quat_in[QX] = quat_x_i;
  assign quat_in[QY] = quat_y_i;
  assign quat_in[QZ] = quat_z_i;
  assign vec_in[0]   = vec_x_i;
  assign vec_in[1]   = vec_y_i;
  assign vec_in[2]   = vec_z_i;

  // Stage 0: all twelve vector by quaternion products.
  for (genvar i = 0; i < NUM_VEC; i++) begin : g_prod
    for (genvar j = 0; j < NUM_QUAT; j++) begin : g_q
      assign prod_d[i][j] = vec_in[i] * quat_in[j];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      prod_q  <= prod_d;
      quat0_q <= quat_in;
    end
  end

  // Stage 1: first Hamilton product t = q * (0, v).
  assign tq_d[QW] = -(TW'(prod_q[0][QX]) + TW'(prod_q[1][QY]) + TW'(prod_q[2][QZ]));
  assign tq_d[QX] = TW'(prod_q[0][QW]) + TW'(prod_q[2][QY]) - TW'(prod_q[1][QZ]);
  assign tq_d[QY] = TW'(prod_q[1][QW]) - TW'(prod_q[2][QX]) + TW'(prod_q[0][QZ]);
  assign tq_d[QZ] = TW'(prod_q[2][QW]) + TW'(prod_q[1][QX]) - TW'(prod_q[0][QY]);

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      tq_q    <= tq_d;
      quat1_q <= quat0_q;
    end
  end

  // Stage 2: second product terms, with t split into an unsigned low half
  // and a signed high half to keep each multiplier narrow.
  for (genvar c = 0; c < NUM_VEC; c++) begin : g_term
    for (genvar n = 0; n < NUM_TERMS; n++) begin : g_n
      logic [LW-1:0]        t_lo;
      logic signed [HW-1:0] t_hi;
      assign t_lo        = tq_q[TERM_T[c][n]][LW-1:0];
      assign t_hi        = $signed(tq_q[TERM_T[c][n]][TW-1:LW]);
      assign lo_d[c][n]  = $signed({1'b0, t_lo}) * quat1_q[TERM_Q[c][n]];
      assign hi_d[c][n]  = t_hi * quat1_q[TERM_Q[c][n]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end

  // Stage 3: signed sums of the low and high partial products.
  always_comb begin
    for (int c = 0; c < NUM_VEC; c++) begin
      losum_d[c] = '0;
      hisum_d[c] = '0;
      for (int n = 0; n < NUM_TERMS; n++) begin
        if (TERM_NEG[c][n]) begin
          losum_d[c] = losum_d[c] - LSW'(lo_q[c][n]);
          hisum_d[c] = hisum_d[c] - HSW'(hi_q[c][n]);
        end else begin
          losum_d[c] = losum_d[c] + LSW'(lo_q[c][n]);
          hisum_d[c] = hisum_d[c] + HSW'(hi_q[c][n]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      losum_q <= losum_d;
      hisum_q <= hisum_d;
    end
  end

  // Stage 4: recombine the halves and add the rounding half.
  for (genvar c = 0; c < NUM_VEC; c++) begin : g_comb
    assign rsum_d[c] = (RW'(hisum_q[c]) <<< LW) + RW'(losum_q[c]) + $signed(RoundHalf);
  end

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      rsum_q <= rsum_d;
    end
  end

  // Stage 5: fraction drop and saturation into the output register.
  for (genvar c = 0; c < NUM_VEC; c++) begin : g_fin
    qvr_round_sat #(
      .IN_WIDTH  (RW),
      .OUT_WIDTH (VEC_WIDTH),
      .FRAC_SHIFT(FracShift)
    ) u_round_sat (
      .value_i(rsum_q[c]),
      .value_o(rot_d[c]),
      .clip_o (clip_vec[c])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      rot_q  <= rot_d;
      clip_q <= |clip_vec;
    end
  end

  assign rot_x_o   = rot_q[0];
  assign rot_y_o   = rot_q[1];
  assign rot_z_o   = rot_q[2];
  assign clipped_o = clip_q;

endmodule
